FILE: hw/rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, constants, register codes and stage payload types for the
// barometric pressure / temperature compensation pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpc_pkg;

  // Field widths
  localparam int RAW_W      = 24;
  localparam int COEF_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int TEMP_OUT_W = 15;
  localparam int PRES_OUT_W = 17;

  // Internal widths, sized to the value ranges of each term
  localparam int DT_W    = 25;  // D2 - C5*256
  localparam int MUL_W   = 42;  // dT times a coefficient
  localparam int SQD_W   = 50;  // dT squared
  localparam int T1_W    = 19;  // first-order temperature, deviation, cold term
  localparam int SQP_W   = 38;  // square of a T1_W value
  localparam int SQ_W    = 35;  // squares kept
  localparam int T2_W    = 18;
  localparam int OFF_W   = 37;
  localparam int SENS_W  = 36;
  localparam int TF_W    = 20;  // corrected temperature
  localparam int OFF2_W  = 40;
  localparam int SENS2_W = 39;
  localparam int OFFF_W  = 41;
  localparam int SENSF_W = 40;
  localparam int SPLIT_W = 20;  // low slice of SENS for the split multiply
  localparam int PL_W    = 44;
  localparam int PH_W    = 45;
  localparam int PROD_W  = 64;
  localparam int DIFF_W  = 44;
  localparam int PRAW_W  = 29;

  // Shift amounts (all arithmetic, floor)
  localparam int SH_TEMP = 23;
  localparam int SH_OFF  = 6;
  localparam int SH_SENS = 7;
  localparam int SH_T2   = 31;
  localparam int SH_OFF2 = 4;
  localparam int SH_P1   = 21;
  localparam int SH_P2   = 15;

  // Scheme constants
  localparam int TEMP_BASE = 2000;
  localparam int COLD_OFS  = 3500;   // (TEMP + 1500) expressed from TEMP - 2000
  localparam int COLD_LIM  = -3500;  // TEMP < -1500 expressed on TEMP - 2000
  localparam int K_OFF2    = 61;
  localparam int K_OFF2C   = 15;
  localparam int SH_SENS2  = 1;      // 2 * sq
  localparam int SH_SENS2C = 3;      // 8 * csq

  // Output ranges
  localparam int TEMP_MIN = -4000;
  localparam int TEMP_MAX = 8500;
  localparam int PRES_MAX = 131071;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS  = 3'd0,
    REG_OFF   = 3'd1,
    REG_TCS   = 3'd2,
    REG_TCO   = 3'd3,
    REG_TREF  = 3'd4,
    REG_TSENS = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] off;
    logic [COEF_W-1:0] tcs;
    logic [COEF_W-1:0] tco;
    logic [COEF_W-1:0] tref;
    logic [COEF_W-1:0] tsens;
  } coef_t;

  // Payload between first-order section and correction section
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [T1_W-1:0]   temp;
    logic [T2_W-1:0]          t2;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
    logic [SQ_W-1:0]          sq;
    logic [SQ_W-1:0]          csq;
    logic                     low_temp;
    logic                     cold_temp;
  } mid_t;

  // Payload from correction section to output stage
  typedef struct packed {
    logic signed [TF_W-1:0]   temp_f;
    logic signed [PRAW_W-1:0] pres_raw;
  } corr_t;

endpackage

FILE: hw/rtl/bpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpc_cfg_regs
// Calibration word register file, write only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bpc_pkg::COEF_W-1:0]     cfg_wdata_i,
  output bpc_pkg::coef_t                 coef_o
);
  import bpc_pkg::*;

  coef_t coef_q;
  coef_t coef_d;

  always_comb begin
    coef_d = coef_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SENS:  coef_d.sens  = cfg_wdata_i;
        REG_OFF:   coef_d.off   = cfg_wdata_i;
        REG_TCS:   coef_d.tcs   = cfg_wdata_i;
        REG_TCO:   coef_d.tco   = cfg_wdata_i;
        REG_TREF:  coef_d.tref  = cfg_wdata_i;
        REG_TSENS: coef_d.tsens = cfg_wdata_i;
        default:   coef_d = coef_q;  // unused indexes are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

FILE: hw/rtl/bpc_first_order.sv
// ----------------------------------------------------------------------------
// bpc_first_order
// Four stages: dT, coefficient products, first-order TEMP/OFF/SENS, squares
// for the low-temperature correction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpc_first_order #(
  parameter int RAW_WIDTH = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bpc_pkg::coef_t             coef_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [bpc_pkg::RAW_W-1:0]  raw_pressure_i,
  input  logic [bpc_pkg::RAW_W-1:0]  raw_temperature_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bpc_pkg::mid_t              out_data_o
);
  import bpc_pkg::*;

  localparam int NST = 4;

  logic [NST-1:0] vld_q;
  logic [NST-1:0] vld_d;
  logic [NST-1:0] adv;

  // A stage loads when empty or when the next one loads
  always_comb begin
    adv[NST-1] = !vld_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign vld_d = {vld_q[NST-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NST-1];

  // ---- stage 1: dT ----
  logic [RAW_WIDTH-1:0]   d1_s1_q;
  logic signed [DT_W-1:0] dt_d, dt_s1_q;

  assign dt_d = $signed({1'b0, RAW_W'(raw_temperature_i[RAW_WIDTH-1:0])})
              - $signed({1'b0, coef_i.tref, 8'h00});

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      d1_s1_q <= raw_pressure_i[RAW_WIDTH-1:0];
      dt_s1_q <= dt_d;
    end
  end

  // ---- stage 2: products of dT ----
  logic [RAW_WIDTH-1:0]    d1_s2_q;
  logic signed [MUL_W-1:0] p6_d, p4_d, p3_d, p6_s2_q, p4_s2_q, p3_s2_q;
  logic signed [SQD_W-1:0] dsq_d, dsq_s2_q;

  assign p6_d  = MUL_W'(dt_s1_q) * MUL_W'($signed({1'b0, coef_i.tsens}));
  assign p4_d  = MUL_W'(dt_s1_q) * MUL_W'($signed({1'b0, coef_i.tco}));
  assign p3_d  = MUL_W'(dt_s1_q) * MUL_W'($signed({1'b0, coef_i.tcs}));
  assign dsq_d = SQD_W'(dt_s1_q) * SQD_W'(dt_s1_q);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      d1_s2_q  <= d1_s1_q;
      p6_s2_q  <= p6_d;
      p4_s2_q  <= p4_d;
      p3_s2_q  <= p3_d;
      dsq_s2_q <= dsq_d;
    end
  end

  // ---- stage 3: first-order terms ----
  logic signed [T1_W-1:0]   dev;
  logic signed [T1_W-1:0]   temp_d, cold_d;
  logic signed [OFF_W-1:0]  off_d;
  logic signed [SENS_W-1:0] sens_d;
  logic [T2_W-1:0]          t2_d;

  logic [RAW_WIDTH-1:0]     d1_s3_q;
  logic signed [T1_W-1:0]   temp_s3_q, dev_s3_q, cold_s3_q;
  logic signed [OFF_W-1:0]  off_s3_q;
  logic signed [SENS_W-1:0] sens_s3_q;
  logic [T2_W-1:0]          t2_s3_q;
  logic                     low_s3_q, coldf_s3_q;

  // dev = TEMP - 2000
  assign dev    = $signed(p6_s2_q[MUL_W-1:SH_TEMP]);
  assign temp_d = dev + T1_W'(TEMP_BASE);
  assign cold_d = dev + T1_W'(COLD_OFS);
  assign off_d  = OFF_W'($signed({1'b0, coef_i.off, 17'b0}))
                + OFF_W'($signed(p4_s2_q[MUL_W-1:SH_OFF]));
  assign sens_d = SENS_W'($signed({1'b0, coef_i.sens, 16'b0}))
                + SENS_W'($signed(p3_s2_q[MUL_W-1:SH_SENS]));
  assign t2_d   = dsq_s2_q[SH_T2+T2_W-1:SH_T2];

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      d1_s3_q    <= d1_s2_q;
      temp_s3_q  <= temp_d;
      dev_s3_q   <= dev;
      cold_s3_q  <= cold_d;
      off_s3_q   <= off_d;
      sens_s3_q  <= sens_d;
      t2_s3_q    <= t2_d;
      low_s3_q   <= dev[T1_W-1];
      coldf_s3_q <= (dev < T1_W'(COLD_LIM));
    end
  end

  // ---- stage 4: squares ----
  logic signed [SQP_W-1:0] sqp, csqp;

  assign sqp  = SQP_W'(dev_s3_q) * SQP_W'(dev_s3_q);
  assign csqp = SQP_W'(cold_s3_q) * SQP_W'(cold_s3_q);

  mid_t mid_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      mid_q.d1        <= RAW_W'(d1_s3_q);
      mid_q.temp      <= temp_s3_q;
      mid_q.t2        <= t2_s3_q;
      mid_q.off       <= off_s3_q;
      mid_q.sens      <= sens_s3_q;
      mid_q.sq        <= sqp[SQ_W-1:0];
      mid_q.csq       <= csqp[SQ_W-1:0];
      mid_q.low_temp  <= low_s3_q;
      mid_q.cold_temp <= coldf_s3_q;
    end
  end

  assign out_data_o = mid_q;

endmodule

FILE: hw/rtl/bpc_correction.sv
// ----------------------------------------------------------------------------
// bpc_correction
// Five stages: second-order terms, corrected OFF/SENS, split D1*SENS
// multiply, product sum, pressure shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpc_correction (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bpc_pkg::mid_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bpc_pkg::corr_t  out_data_o
);
  import bpc_pkg::*;

  localparam int NST = 5;

  logic [NST-1:0] vld_q;
  logic [NST-1:0] vld_d;
  logic [NST-1:0] adv;

  always_comb begin
    adv[NST-1] = !vld_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign vld_d = {vld_q[NST-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NST-1];

  // ---- stage 5: OFF2, SENS2, TEMP - T2 ----
  logic [OFF2_W-1:0]  off2_a, off2_b, off2_d;
  logic [SENS2_W-1:0] sens2_d;
  logic signed [TF_W-1:0] tf_d;

  assign off2_a = (OFF2_W'(in_data_i.sq) * OFF2_W'(K_OFF2)) >> SH_OFF2;
  assign off2_b = OFF2_W'(in_data_i.csq) * OFF2_W'(K_OFF2C);

  always_comb begin
    off2_d  = '0;
    sens2_d = '0;
    tf_d    = TF_W'(in_data_i.temp);
    if (in_data_i.low_temp) begin
      off2_d  = off2_a;
      sens2_d = SENS2_W'(in_data_i.sq) << SH_SENS2;
      tf_d    = TF_W'(in_data_i.temp) - $signed({2'b00, in_data_i.t2});
      if (in_data_i.cold_temp) begin
        off2_d  = off2_a + off2_b;
        sens2_d = (SENS2_W'(in_data_i.sq) << SH_SENS2)
                + (SENS2_W'(in_data_i.csq) << SH_SENS2C);
      end
    end
  end

  logic [RAW_W-1:0]         d1_s5_q;
  logic signed [TF_W-1:0]   tf_s5_q;
  logic signed [OFF_W-1:0]  off_s5_q;
  logic signed [SENS_W-1:0] sens_s5_q;
  logic [OFF2_W-1:0]        off2_s5_q;
  logic [SENS2_W-1:0]       sens2_s5_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      d1_s5_q    <= in_data_i.d1;
      tf_s5_q    <= tf_d;
      off_s5_q   <= in_data_i.off;
      sens_s5_q  <= in_data_i.sens;
      off2_s5_q  <= off2_d;
      sens2_s5_q <= sens2_d;
    end
  end

  // ---- stage 6: corrected OFF and SENS ----
  logic [RAW_W-1:0]          d1_s6_q;
  logic signed [TF_W-1:0]    tf_s6_q;
  logic signed [OFFF_W-1:0]  offf_s6_q;
  logic signed [SENSF_W-1:0] sensf_s6_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      d1_s6_q    <= d1_s5_q;
      tf_s6_q    <= tf_s5_q;
      offf_s6_q  <= OFFF_W'(off_s5_q) - $signed({1'b0, off2_s5_q});
      sensf_s6_q <= SENSF_W'(sens_s5_q) - $signed({1'b0, sens2_s5_q});
    end
  end

  // ---- stage 7: D1 * SENS as two partial products ----
  logic [PL_W-1:0]          pl_d;
  logic signed [PH_W-1:0]   ph_d;
  logic signed [TF_W-1:0]   tf_s7_q;
  logic signed [OFFF_W-1:0] offf_s7_q;
  logic [PL_W-1:0]          pl_s7_q;
  logic signed [PH_W-1:0]   ph_s7_q;

  assign pl_d = PL_W'(d1_s6_q) * PL_W'(sensf_s6_q[SPLIT_W-1:0]);
  assign ph_d = PH_W'($signed({1'b0, d1_s6_q}))
              * PH_W'($signed(sensf_s6_q[SENSF_W-1:SPLIT_W]));

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      tf_s7_q   <= tf_s6_q;
      offf_s7_q <= offf_s6_q;
      pl_s7_q   <= pl_d;
      ph_s7_q   <= ph_d;
    end
  end

  // ---- stage 8: recombine ----
  logic signed [TF_W-1:0]   tf_s8_q;
  logic signed [OFFF_W-1:0] offf_s8_q;
  logic signed [PROD_W-1:0] prod_s8_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      tf_s8_q   <= tf_s7_q;
      offf_s8_q <= offf_s7_q;
      prod_s8_q <= (PROD_W'(ph_s7_q) <<< SPLIT_W) + $signed(PROD_W'(pl_s7_q));
    end
  end

  // ---- stage 9: P = ((D1*SENS >> 21) - OFF) >> 15 ----
  logic signed [DIFF_W-1:0] diff;
  corr_t corr_q;

  assign diff = DIFF_W'($signed(prod_s8_q[PROD_W-1:SH_P1])) - DIFF_W'(offf_s8_q);

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      corr_q.temp_f   <= tf_s8_q;
      corr_q.pres_raw <= $signed(diff[DIFF_W-1:SH_P2]);
    end
  end

  assign out_data_o = corr_q;

endmodule

FILE: hw/rtl/baro_pressure_temp_compensation_top.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_top
// Pipeline: 10 register stages, from dT through the output clamp; a result
// moves through them in order and shows on out_valid_o from the last one.
// Throughput: one request per cycle unless the result side stalls; every stage
// holds one item, and the pressure multiply is split 24 x 40 bit.
// Reset: rst_ni clears all valid bits and the six calibration words to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_top #(
  parameter int RAW_WIDTH = 24
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // calibration write port
  input  logic                                   cfg_we_i,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [bpc_pkg::COEF_W-1:0]             cfg_wdata_i,
  // request channel
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [bpc_pkg::RAW_W-1:0]              raw_pressure_i,
  input  logic [bpc_pkg::RAW_W-1:0]              raw_temperature_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [bpc_pkg::TEMP_OUT_W-1:0]  temperature_centi_o,
  output logic [bpc_pkg::PRES_OUT_W-1:0]         pressure_pa_o,
  output logic                                   out_of_range_o
);
  import bpc_pkg::*;

  coef_t coef;

  // Calibration words. The user must write them only while the pipe is empty;
  // the block does not enforce this, and the stages read them live.
  bpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef)
  );

  // Stages 1-4: dT, coefficient products, first-order terms, squares.
  logic mid_valid, mid_ready;
  mid_t mid_data;

  bpc_first_order #(
    .RAW_WIDTH (RAW_WIDTH)
  ) u_first (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .coef_i            (coef),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .out_valid_o       (mid_valid),
    .out_ready_i       (mid_ready),
    .out_data_o        (mid_data)
  );

  // Stages 5-9: second-order correction and pressure.
  logic  corr_valid, corr_ready;
  corr_t corr_data;

  bpc_correction u_corr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_data_i   (mid_data),
    .out_valid_o (corr_valid),
    .out_ready_i (corr_ready),
    .out_data_o  (corr_data)
  );

  // Stage 10: clamp both results and register them. Each stage upstream
  // loads whenever it is empty, so bubbles close up while a result waits.
  logic                          temp_lo, temp_hi, pres_lo, pres_hi;
  logic signed [TEMP_OUT_W-1:0]  temp_sat;
  logic [PRES_OUT_W-1:0]         pres_sat;

  assign temp_lo = corr_data.temp_f < TF_W'(TEMP_MIN);
  assign temp_hi = corr_data.temp_f > TF_W'(TEMP_MAX);
  assign pres_lo = corr_data.pres_raw[PRAW_W-1];
  assign pres_hi = corr_data.pres_raw > PRAW_W'(PRES_MAX);

  always_comb begin
    if (temp_lo) begin
      temp_sat = TEMP_OUT_W'(TEMP_MIN);
    end else if (temp_hi) begin
      temp_sat = TEMP_OUT_W'(TEMP_MAX);
    end else begin
      temp_sat = corr_data.temp_f[TEMP_OUT_W-1:0];
    end

    if (pres_lo) begin
      pres_sat = '0;
    end else if (pres_hi) begin
      pres_sat = PRES_OUT_W'(PRES_MAX);
    end else begin
      pres_sat = corr_data.pres_raw[PRES_OUT_W-1:0];
    end
  end

  logic                          out_valid_q;
  logic signed [TEMP_OUT_W-1:0]  temp_q;
  logic [PRES_OUT_W-1:0]         pres_q;
  logic                          oor_q;

  assign corr_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (corr_ready) begin
      out_valid_q <= corr_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (corr_ready) begin
      temp_q <= temp_sat;
      pres_q <= pres_sat;
      oor_q  <= temp_lo || temp_hi || pres_lo || pres_hi;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign temperature_centi_o = temp_q;
  assign pressure_pa_o       = pres_q;
  assign out_of_range_o      = oor_q;

endmodule

FILE: tb/sv/tb_baro_pressure_temp_compensation_top.sv
// ----------------------------------------------------------------------------
// tb_baro_pressure_temp_compensation_top
// Self-checking bench for the pressure / temperature compensation pipeline.
// A directed table covers reset state, field extremes, ignored register
// indexes and every clamp path. Random phases follow, each under its own
// calibration set. Accepted requests without a typed expectation are predicted
// in 64-bit signed math; all are matched in order against the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_baro_pressure_temp_compensation_top;
  import bpc_pkg::*;

  localparam int RAW_WIDTH     = 24;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int N_PHASES      = 8;
  localparam int PHASE_ITEMS   = 180;
  localparam int HOLD_AT       = 300;   // accepted requests before the long stall
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 20;    // pipeline is 10 deep
  localparam int COLD_BASE     = -1500; // extra cold term threshold
  localparam int K_SENS2       = 2;
  localparam int K_SENS2C      = 8;
  localparam int SH_TREF       = 8;     // C5 * 256
  localparam int SH_OFF_BASE   = 17;    // C2 * 2^17
  localparam int SH_SENS_BASE  = 16;    // C1 * 2^16
  localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
  localparam logic [COEF_W-1:0] COEF_MAX = {COEF_W{1'b1}};

  // indexes the block decodes to nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic signed [TEMP_OUT_W-1:0] temp;
    logic [PRES_OUT_W-1:0]        pres;
    logic                         oor;
  } reading_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // one line of the directed table: either a register write or a request,
  // with the expected reading typed in only where it is obvious
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [COEF_W-1:0]     val;
    logic [RAW_W-1:0]      pres;
    logic [RAW_W-1:0]      temp;
    logic                  pinned;
    reading_t              want;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [COEF_W-1:0]     cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [RAW_W-1:0]      raw_pressure_i = '0;
  logic [RAW_W-1:0]      raw_temperature_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic signed [TEMP_OUT_W-1:0] temperature_centi_o;
  logic [PRES_OUT_W-1:0] pressure_pa_o;
  logic                  out_of_range_o;

  // calibration words as the block should hold them
  coef_t cal = '0;

  reading_t expected_readings[$];
  row_t     dir_rows[$];

  // request currently offered carries a typed expectation (moves with payload)
  logic     pin_on = 1'b0;
  reading_t pin_val = '0;

  int  n_accepted = 0;
  int  n_mismatch = 0;
  int  n_cycles = 0;
  bit  calm = 1'b0;      // phase without any idling on either side
  bit  hold_done = 1'b0;

  baro_pressure_temp_compensation_top #(
    .RAW_WIDTH(RAW_WIDTH)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .raw_pressure_i      (raw_pressure_i),
    .raw_temperature_i   (raw_temperature_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .temperature_centi_o (temperature_centi_o),
    .pressure_pa_o       (pressure_pa_o),
    .out_of_range_o      (out_of_range_o)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Compensation predictor: first order terms, second order correction below
  // 20.00 C, extra cold term below -15.00 C, then clamp. All shifts floor.
  // --------------------------------------------------------------------------
  function automatic reading_t compensate(input logic [RAW_W-1:0] p_raw,
                                          input logic [RAW_W-1:0] t_raw);
    logic [RAW_W-1:0] keep;
    longint d1, d2, dt, t, off, sens, t2, off2, sens2, dev, sq, cold, csq, p;
    logic   clip;
    reading_t r;
    keep  = RAW_MAX >> (RAW_W - RAW_WIDTH);
    d1    = longint'(p_raw & keep);
    d2    = longint'(t_raw & keep);
    dt    = d2 - (longint'(cal.tref) <<< SH_TREF);
    t     = TEMP_BASE + ((dt * longint'(cal.tsens)) >>> SH_TEMP);
    off   = (longint'(cal.off) <<< SH_OFF_BASE) + ((longint'(cal.tco) * dt) >>> SH_OFF);
    sens  = (longint'(cal.sens) <<< SH_SENS_BASE) + ((longint'(cal.tcs) * dt) >>> SH_SENS);
    t2    = 0;
    off2  = 0;
    sens2 = 0;
    if (t < TEMP_BASE) begin
      dev   = t - TEMP_BASE;
      sq    = dev * dev;
      t2    = (dt * dt) >>> SH_T2;
      off2  = (K_OFF2 * sq) >>> SH_OFF2;
      sens2 = K_SENS2 * sq;
      if (t < COLD_BASE) begin
        cold  = t - COLD_BASE;
        csq   = cold * cold;
        off2  = off2 + K_OFF2C * csq;
        sens2 = sens2 + K_SENS2C * csq;
      end
    end
    t    = t - t2;
    off  = off - off2;
    sens = sens - sens2;
    p    = (((d1 * sens) >>> SH_P1) - off) >>> SH_P2;
    clip = 1'b0;
    if (t < TEMP_MIN) begin t = longint'(TEMP_MIN); clip = 1'b1; end
    if (t > TEMP_MAX) begin t = longint'(TEMP_MAX); clip = 1'b1; end
    if (p < 0) begin p = 0; clip = 1'b1; end
    if (p > PRES_MAX) begin p = longint'(PRES_MAX); clip = 1'b1; end
    r.temp = t[TEMP_OUT_W-1:0];
    r.pres = p[PRES_OUT_W-1:0];
    r.oor  = clip;
    return r;
  endfunction

  // mostly short gaps, now and then a long one; none in a calm phase
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (calm || r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(10, 4);
    return $urandom_range(40, 15);
  endfunction

  // --------------------------------------------------------------------------
  // Directed table builders
  // --------------------------------------------------------------------------
  function automatic void req_row(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
    row_t row;
    row = '0;
    row.kind = ROW_REQ;
    row.pres = p;
    row.temp = t;
    dir_rows.push_back(row);
  endfunction

  function automatic void pinned_row(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t,
                                     input int exp_t, input int exp_p, input logic exp_oor);
    row_t row;
    row = '0;
    row.kind      = ROW_REQ;
    row.pres      = p;
    row.temp      = t;
    row.pinned    = 1'b1;
    row.want.temp = exp_t[TEMP_OUT_W-1:0];
    row.want.pres = exp_p[PRES_OUT_W-1:0];
    row.want.oor  = exp_oor;
    dir_rows.push_back(row);
  endfunction

  function automatic void cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] v);
    row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.val  = v;
    dir_rows.push_back(row);
  endfunction

  function automatic void cal_rows(input coef_t c);
    cfg_row(REG_SENS, c.sens);
    cfg_row(REG_OFF, c.off);
    cfg_row(REG_TCS, c.tcs);
    cfg_row(REG_TCO, c.tco);
    cfg_row(REG_TREF, c.tref);
    cfg_row(REG_TSENS, c.tsens);
  endfunction

  // --------------------------------------------------------------------------
  // Driving tasks; every call starts and ends on a rising edge
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    case (idx)
      REG_SENS:  cal.sens  = v;
      REG_OFF:   cal.off   = v;
      REG_TCS:   cal.tcs   = v;
      REG_TCO:   cal.tco   = v;
      REG_TREF:  cal.tref  = v;
      REG_TSENS: cal.tsens = v;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_req(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t,
                          input logic pinned, input reading_t want);
    int gap;
    in_valid_i        <= 1'b1;
    raw_pressure_i    <= p;
    raw_temperature_i <= t;
    pin_on            <= pinned;
    pin_val           <= want;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Request stimulus: directed table, then random phases
  // --------------------------------------------------------------------------
  initial begin : stimulus
    coef_t   c, typical;
    row_t    row;
    longint  t_word;
    int      sel;
    typical = '{sens: 16'd46372, off: 16'd43981, tcs: 16'd29059,
                tco: 16'd27842, tref: 16'd31553, tsens: 16'd28165};

    // after reset every coefficient is zero: TEMP sits at 20.00 C, P at 0
    pinned_row('0, '0, TEMP_BASE, 0, 1'b0);
    pinned_row(RAW_MAX, RAW_MAX, TEMP_BASE, 0, 1'b0);
    pinned_row(RAW_MAX, '0, TEMP_BASE, 0, 1'b0);
    pinned_row('0, RAW_MAX, TEMP_BASE, 0, 1'b0);
    // writes to undecoded indexes must leave the zero calibration alone
    cfg_row(REG_SPARE_6, COEF_MAX);
    cfg_row(REG_SPARE_7, COEF_MAX);
    pinned_row(24'hAAAAAA, 24'h555555, TEMP_BASE, 0, 1'b0);
    // typical part: warm, below 20 C, below -15 C, clamp low and high
    cal_rows(typical);
    req_row(24'd6465444, 24'd8077636);
    req_row(24'd6465444, 24'd7077568);
    req_row(24'd6465444, 24'd5577568);
    req_row(RAW_MAX, '0);
    req_row('0, RAW_MAX);
    req_row(24'h800000, 24'd8077568);
    // every coefficient at its top
    cal_rows('1);
    req_row('0, '0);
    req_row(RAW_MAX, RAW_MAX);
    req_row(RAW_MAX, '0);
    req_row('0, RAW_MAX);
    req_row(24'h800000, 24'hFF0000);
    // no sensitivity, huge offset: pressure goes negative and clamps to 0
    cfg_row(REG_SENS, '0);
    req_row(RAW_MAX, 24'hFF0000);
    req_row(24'h123456, 24'hFFFF00);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        drain();
        write_reg(row.idx, row.val);
      end else begin
        send_req(row.pres, row.temp, row.pinned, row.want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      calm = (ph == 2) || (ph == 5);
      // alternate realistic sets, full random, and sets built from the edges
      case (ph % 4)
        0, 2: begin
          c.sens  = COEF_W'($urandom_range(55000, 40000));
          c.off   = COEF_W'($urandom_range(55000, 40000));
          c.tcs   = COEF_W'($urandom_range(35000, 20000));
          c.tco   = COEF_W'($urandom_range(35000, 20000));
          c.tref  = COEF_W'($urandom_range(36000, 25000));
          c.tsens = COEF_W'($urandom_range(32000, 24000));
        end
        1: c = {$urandom, $urandom, $urandom};
        default: begin
          c = {$urandom, $urandom, $urandom};
          for (int k = 0; k < 6; k++) begin
            sel = $urandom_range(2, 0);
            if (sel == 0) c[k*COEF_W +: COEF_W] = '0;
            if (sel == 1) c[k*COEF_W +: COEF_W] = COEF_MAX;
          end
        end
      endcase
      write_reg(REG_SENS, c.sens);
      write_reg(REG_OFF, c.off);
      write_reg(REG_TCS, c.tcs);
      write_reg(REG_TCO, c.tco);
      write_reg(REG_TREF, c.tref);
      write_reg(REG_TSENS, c.tsens);
      if ($urandom_range(1, 0)) write_reg($urandom_range(1, 0) ? REG_SPARE_6 : REG_SPARE_7,
                                          COEF_W'($urandom));

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // temperature word mostly near the reference so every branch is hit
        if ($urandom_range(9, 0) < 7) begin
          t_word = (longint'(cal.tref) <<< SH_TREF)
                   + longint'($urandom_range(4500000, 0)) - 3000000;
          if (t_word < 0) t_word = 0;
          if (t_word > longint'(RAW_MAX)) t_word = longint'(RAW_MAX);
        end else begin
          t_word = longint'($urandom) & longint'(RAW_MAX);
        end
        sel = $urandom_range(9, 0);
        send_req((sel == 0) ? '0 :
                 (sel == 1) ? RAW_MAX :
                 (sel < 6)  ? RAW_W'($urandom) :
                              RAW_W'($urandom_range(10000000, 5000000)),
                 t_word[RAW_W-1:0], 1'b0, '0);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls, plus one long hold-off so the pipe fills up
  // and pushes back on the request channel.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        repeat ($urandom_range(calm ? 60 : 12, 1)) @(posedge clk_i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on request accept, compare on result accept.
  // Signals are read in the active region of the edge, i.e. the values the
  // block saw when it sampled.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_readings.push_back(pin_on ? pin_val
                                           : compensate(raw_pressure_i, raw_temperature_i));
        n_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          $error("result with nothing outstanding: temperature_centi %0d pressure_pa %0d",
                 temperature_centi_o, pressure_pa_o);
          n_mismatch++;
        end else begin
          want = expected_readings.pop_front();
          if (temperature_centi_o !== want.temp) begin
            $error("temperature_centi: expected %0d, got %0d", want.temp, temperature_centi_o);
            n_mismatch++;
          end
          if (pressure_pa_o !== want.pres) begin
            $error("pressure_pa: expected %0d, got %0d", want.pres, pressure_pa_o);
            n_mismatch++;
          end
          if (out_of_range_o !== want.oor) begin
            $error("out_of_range: expected %0d, got %0d", want.oor, out_of_range_o);
            n_mismatch++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
